>>> sv/fir_dec_pkg.sv
// Shared types and constants for the decimating FIR filter.
package fir_dec_pkg;

   localparam int MAX_TAPS_DEF = 16;

   localparam int SAMPLE_W   = 16;
   localparam int IDX_W      = 4;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int ACC_W      = 40;
   localparam int TAPCNT_W   = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 5;

   // The coefficient index field cannot address more entries than this.
   localparam int COEF_LIMIT = 2 ** IDX_W;

   localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST = TAPCNT_W'(12);

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_COEF   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DECIMATE  = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_FLUSH,
      ST_DONE
   } fir_state_type;

endpackage

>>> sv/fir_filter_decimating.sv
// Decimating FIR filter built around one shared multiply-accumulate unit.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------------
//   req     | in        | req_valid / req_ready | command, coef_index, value, frame_start
//   rsp     | out       | rsp_valid / rsp_ready | filtered
//   csr     | in        | csr_valid / csr_ready | index, data
//
// A coefficient word is taken while the block stays idle. A sample word keeps the block
// busy: the single multiplier visits every position of the delay line once while the
// line rotates past a fixed read tap, then the flush state drains the multiply and add
// stages and the done state hands the sum to the output register.
// Reset is synchronous; it clears the delay line, the phase and the control registers, but not
// the coefficient store. A waiting result does not block the next input word; the
// sequencer only holds in its last state while the output register is still full.
module fir_filter_decimating #(
   parameter int MAX_TAPS = fir_dec_pkg::MAX_TAPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_command,
   input  logic [fir_dec_pkg::IDX_W-1:0]         req_coef_index,
   input  logic signed [fir_dec_pkg::SAMPLE_W-1:0] req_value,
   input  logic                                  req_frame_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [fir_dec_pkg::ACC_W-1:0]  rsp_filtered,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fir_dec_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fir_dec_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int COEF_DEPTH = (MAX_TAPS < fir_dec_pkg::COEF_LIMIT) ?
                               MAX_TAPS : fir_dec_pkg::COEF_LIMIT;
   localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
   localparam int CNT_W      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TAPS - 1);

   fir_dec_pkg::fir_state_type state_ff, state_in;

   logic [fir_dec_pkg::TAPCNT_W-1:0] tap_count_ff;
   logic                             decimate_ff;
   logic                             odd_phase_ff, odd_phase_in;
   logic                             emit_ff, emit_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic                             flush_ff, flush_in;

   logic signed [fir_dec_pkg::SAMPLE_W-1:0] tap_ff [MAX_TAPS];
   logic signed [fir_dec_pkg::SAMPLE_W-1:0] coef_mem [COEF_DEPTH];

   logic signed [fir_dec_pkg::SAMPLE_W-1:0] coef_rd_ff;
   logic signed [fir_dec_pkg::SAMPLE_W-1:0] samp_ff;
   logic                                    use1_ff, use1_in;
   logic signed [fir_dec_pkg::PROD_W-1:0]   prod_ff;
   logic                                    use2_ff;
   logic signed [fir_dec_pkg::ACC_W-1:0]    acc_ff;

   logic                                    rsp_valid_ff;
   logic signed [fir_dec_pkg::ACC_W-1:0]    rsp_filtered_ff;

   logic req_fire, sample_fire, coef_fire, mac_step, out_free, load_out;

   assign req_fire    = req_valid && req_ready;
   assign sample_fire = req_fire && (req_command == fir_dec_pkg::CMD_SAMPLE);
   assign coef_fire   = req_fire && (req_command == fir_dec_pkg::CMD_COEF);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign csr_ready   = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fir_dec_pkg::ST_IDLE: begin
            if (sample_fire) state_in = fir_dec_pkg::ST_MAC;
         end
         fir_dec_pkg::ST_MAC: begin
            if (cnt_ff == CNT_LAST) state_in = fir_dec_pkg::ST_FLUSH;
         end
         fir_dec_pkg::ST_FLUSH: begin
            if (flush_ff) state_in = fir_dec_pkg::ST_DONE;
         end
         fir_dec_pkg::ST_DONE: begin
            if (!emit_ff || out_free) state_in = fir_dec_pkg::ST_IDLE;
         end
         default: state_in = fir_dec_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      mac_step  = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         fir_dec_pkg::ST_IDLE:  req_ready = 1'b1;
         fir_dec_pkg::ST_MAC:   mac_step  = 1'b1;
         fir_dec_pkg::ST_FLUSH: ;
         fir_dec_pkg::ST_DONE:  load_out  = emit_ff && out_free;
         default: ;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (mac_step) cnt_in = (cnt_ff == CNT_LAST) ? '0 : cnt_ff + CNT_W'(1);
      flush_in = (state_ff == fir_dec_pkg::ST_FLUSH) ? !flush_ff : 1'b0;
      // Taps past the configured count, or past the coefficient store, add nothing.
      use1_in = mac_step && (32'(cnt_ff) < 32'(tap_count_ff)) && (32'(cnt_ff) < COEF_DEPTH);
      odd_phase_in = odd_phase_ff;
      emit_in      = emit_ff;
      if (sample_fire) begin
         odd_phase_in = req_frame_start ? 1'b1 : !odd_phase_ff;
         emit_in      = !decimate_ff || req_frame_start || !odd_phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fir_dec_pkg::ST_IDLE;
         tap_count_ff <= fir_dec_pkg::TAP_COUNT_RST;
         decimate_ff  <= 1'b0;
         odd_phase_ff <= 1'b0;
         emit_ff      <= 1'b0;
         cnt_ff       <= '0;
         flush_ff     <= 1'b0;
         use1_ff      <= 1'b0;
         use2_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         odd_phase_ff <= odd_phase_in;
         emit_ff      <= emit_in;
         cnt_ff       <= cnt_in;
         flush_ff     <= flush_in;
         use1_ff      <= use1_in;
         use2_ff      <= use1_ff;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fir_dec_pkg::CSR_TAP_COUNT: tap_count_ff <= csr_data[fir_dec_pkg::TAPCNT_W-1:0];
               fir_dec_pkg::CSR_DECIMATE:  decimate_ff  <= csr_data[0];
               default: ;
            endcase
         end
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Delay line: shifts on a sample word, then rotates once per tap so that every
   // position passes the read tap at index zero and the line ends up restored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) tap_ff[i] <= '0;
      end else if (sample_fire) begin
         tap_ff[0] <= req_value;
         for (int i = 1; i < MAX_TAPS; i++) tap_ff[i] <= req_frame_start ? '0 : tap_ff[i-1];
      end else if (mac_step) begin
         for (int i = 0; i < MAX_TAPS - 1; i++) tap_ff[i] <= tap_ff[i+1];
         tap_ff[MAX_TAPS-1] <= tap_ff[0];
      end
   end

   // Coefficient store with a registered read port.
   always_ff @(posedge clock) begin
      if (coef_fire && (32'(req_coef_index) < COEF_DEPTH)) begin
         coef_mem[req_coef_index[COEF_AW-1:0]] <= req_value;
      end
      coef_rd_ff <= coef_mem[cnt_ff[COEF_AW-1:0]];
   end

   // Multiply and accumulate stages.
   always_ff @(posedge clock) begin
      samp_ff <= tap_ff[0];
      prod_ff <= coef_rd_ff * samp_ff;
      if (sample_fire) acc_ff <= '0;
      else if (use2_ff) acc_ff <= acc_ff + fir_dec_pkg::ACC_W'(prod_ff);
      if (load_out) rsp_filtered_ff <= acc_ff;
   end

   a_acc_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      use2_ff |-> (state_ff == fir_dec_pkg::ST_MAC || state_ff == fir_dec_pkg::ST_FLUSH))
      else $error("accumulator updated outside the tap sweep");

   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fir_dec_pkg::ST_IDLE) |-> (cnt_ff == '0))
      else $error("tap counter not back at zero when idle");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fir_dec_pkg::ST_DONE && emit_ff && out_free) |=> rsp_valid_ff)
      else $error("finished sum did not reach the output register");

endmodule

>>> tb/tb_fir_filter_decimating.sv
// Self-checking testbench for the decimating FIR filter: directed table, then random frames.
`timescale 1ns / 1ps

module tb_fir_filter_decimating;

   localparam int N_TAPS        = fir_dec_pkg::MAX_TAPS_DEF;
   localparam int IDX_W         = fir_dec_pkg::IDX_W;
   localparam int SAMPLE_W      = fir_dec_pkg::SAMPLE_W;
   localparam int ACC_W         = fir_dec_pkg::ACC_W;
   localparam int TAPCNT_W      = fir_dec_pkg::TAPCNT_W;
   localparam int CSR_IDX_W     = fir_dec_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W    = fir_dec_pkg::CSR_DATA_W;
   localparam int SETTLE_CYCLES = 2 * (N_TAPS + 4);
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int N_DIRECTED    = 28;
   localparam int N_PHASES      = 9;
   localparam int PHASE_WORDS   = 180;

   localparam logic CMD_SAMPLE = fir_dec_pkg::CMD_SAMPLE;
   localparam logic CMD_COEF   = fir_dec_pkg::CMD_COEF;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT = fir_dec_pkg::CSR_TAP_COUNT;
   localparam logic [CSR_IDX_W-1:0] CSR_DECIMATE  = fir_dec_pkg::CSR_DECIMATE;

   // Index with no register behind it; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(15);

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic                     command;
      logic [IDX_W-1:0]         coef_index;
      logic [SAMPLE_W-1:0]      value;
      logic                     frame_start;
      logic                     pinned;
      logic [ACC_W-1:0]         pinned_sum;
      logic [CSR_IDX_W-1:0]     csr_idx;
      logic [CSR_DATA_W-1:0]    csr_val;
   } row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_command = CMD_SAMPLE;
   logic [IDX_W-1:0]             req_coef_index = '0;
   logic signed [SAMPLE_W-1:0]   req_value = '0;
   logic                         req_frame_start = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [ACC_W-1:0]      rsp_filtered;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_data = '0;

   // Predictor state.
   logic signed [SAMPLE_W-1:0]   coef_copy [N_TAPS];
   logic signed [SAMPLE_W-1:0]   history [N_TAPS];
   logic                         phase_odd = 1'b0;
   logic [TAPCNT_W-1:0]          taps_setting = fir_dec_pkg::TAP_COUNT_RST;
   logic                         decimate_setting = 1'b0;
   logic                         last_word_summed;
   logic signed [ACC_W-1:0]      expected_sums [$];
   logic signed [ACC_W-1:0]      wanted_sum;

   int unsigned cycle_count = 0;
   int          mismatches = 0;
   int          sums_checked = 0;
   int          words_sent = 0;
   int          samples_sent = 0;
   int          coef_loads = 0;
   int          csr_writes = 0;
   int          req_idle_pct = 33;
   int          rsp_idle_pct = 57;

   logic [TAPCNT_W-1:0] phase_taps [N_PHASES] =
      '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd16, 5'd3, 5'd31, 5'd9};
   logic                phase_decim [N_PHASES] =
      '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

   // Coefficients are all zero when this table starts, tap count 12, no decimation.
   row_type directed_rows [N_DIRECTED] = '{
      '{ROW_WORD, CMD_SAMPLE, 4'd0,  16'h1234, 1'b1, 1'b1, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_CSR,  CMD_SAMPLE, 4'd0,  16'h0000, 1'b0, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_WORD, CMD_COEF,   4'd0,  16'h7FFF, 1'b1, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_WORD, CMD_SAMPLE, 4'd0,  16'h7FFF, 1'b0, 1'b1, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_CSR,  CMD_SAMPLE, 4'd0,  16'h0000, 1'b0, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd1},
      '{ROW_WORD, CMD_SAMPLE, 4'd0,  16'h7FFF, 1'b0, 1'b1, 40'd1073676289,
        CSR_TAP_COUNT, 5'd0},
      '{ROW_WORD, CMD_COEF,   4'd0,  16'h8000, 1'b0, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_WORD, CMD_SAMPLE, 4'd0,  16'h8000, 1'b1, 1'b1, 40'd1073741824,
        CSR_TAP_COUNT, 5'd0},
      '{ROW_WORD, CMD_SAMPLE, 4'd0,  16'h7FFF, 1'b0, 1'b1, -40'sd1073709056,
        CSR_TAP_COUNT, 5'd0},
      '{ROW_WORD, CMD_COEF,   4'd15, 16'h7FFF, 1'b1, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_WORD, CMD_COEF,   4'd1,  16'h0001, 1'b0, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_CSR,  CMD_SAMPLE, 4'd0,  16'h0000, 1'b0, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd2},
      '{ROW_WORD, CMD_SAMPLE, 4'd9,  16'h0000, 1'b0, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_CSR,  CMD_SAMPLE, 4'd0,  16'h0000, 1'b0, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd31},
      '{ROW_WORD, CMD_SAMPLE, 4'd0,  16'h4000, 1'b0, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_CSR,  CMD_SAMPLE, 4'd0,  16'h0000, 1'b0, 1'b0, 40'd0, CSR_DECIMATE,  5'd1},
      '{ROW_WORD, CMD_SAMPLE, 4'd0,  16'h7FFF, 1'b1, 1'b1, -40'sd1073709056,
        CSR_TAP_COUNT, 5'd0},
      '{ROW_WORD, CMD_SAMPLE, 4'd0,  16'h0100, 1'b0, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_WORD, CMD_SAMPLE, 4'd0,  16'h0200, 1'b0, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_WORD, CMD_SAMPLE, 4'd0,  16'h0300, 1'b0, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_CSR,  CMD_SAMPLE, 4'd0,  16'h0000, 1'b0, 1'b0, 40'd0, CSR_DECIMATE,  5'd0},
      '{ROW_WORD, CMD_SAMPLE, 4'd0,  16'h0400, 1'b0, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_CSR,  CMD_SAMPLE, 4'd0,  16'h0000, 1'b0, 1'b0, 40'd0, CSR_DECIMATE,  5'd1},
      '{ROW_WORD, CMD_SAMPLE, 4'd0,  16'h0500, 1'b0, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_WORD, CMD_SAMPLE, 4'd0,  16'h0600, 1'b0, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_CSR,  CMD_SAMPLE, 4'd0,  16'h0000, 1'b0, 1'b0, 40'd0, CSR_UNUSED,    5'd31},
      '{ROW_WORD, CMD_SAMPLE, 4'd0,  16'hFFFF, 1'b1, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd0},
      '{ROW_WORD, CMD_SAMPLE, 4'd0,  16'h8000, 1'b1, 1'b0, 40'd0, CSR_TAP_COUNT, 5'd0}
   };

   fir_filter_decimating DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_coef_index  (req_coef_index),
      .req_value       (req_value),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_filtered    (rsp_filtered),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_fir_filter_decimating: done, errors");
      $finish;
   end

   // Works out the filter sum that one accepted word causes, if any.
   task automatic predict_filter(input logic cmd, input logic [IDX_W-1:0] idx,
                                 input logic signed [SAMPLE_W-1:0] val, input logic fs);
      logic signed [ACC_W-1:0] sum;
      int active;
      sum = '0;
      last_word_summed = 1'b0;
      if (cmd == CMD_COEF) begin
         if (idx < N_TAPS) begin
            coef_copy[idx] = val;
         end
      end else begin
         if (fs) begin
            for (int j = 0; j < N_TAPS; j++) history[j] = '0;
            phase_odd = 1'b0;
         end
         for (int j = N_TAPS - 1; j > 0; j--) history[j] = history[j-1];
         history[0] = val;
         active = (taps_setting > N_TAPS) ? N_TAPS : taps_setting;
         for (int j = 0; j < active; j++) sum = sum + coef_copy[j] * history[j];
         if (!decimate_setting || !phase_odd) begin
            expected_sums.push_back(sum);
            last_word_summed = 1'b1;
         end
         phase_odd = ~phase_odd;
      end
   endtask

   task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx,
                            input logic signed [SAMPLE_W-1:0] val, input logic fs);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < req_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_coef_index  <= idx;
      req_value       <= val;
      req_frame_start <= fs;
      do @(posedge clock); while (!req_ready);
      predict_filter(cmd, idx, val, fs);
      words_sent++;
      if (cmd == CMD_COEF) coef_loads++;
      else samples_sent++;
   endtask

   // Stops sending and waits for every outstanding sum.
   task automatic wait_for_sums();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_sums.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      wait_for_sums();
      // A sample that produces no sum may still be in the accumulator.
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      if (idx == CSR_TAP_COUNT) taps_setting = val;
      else if (idx == CSR_DECIMATE) decimate_setting = val[0];
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_extreme();
      return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
   endfunction

   // One series: an optional tap reload, a frame start, then samples with some noise mixed in.
   task automatic send_frame();
      int length;
      logic harsh;
      logic signed [SAMPLE_W-1:0] coef_level;
      logic signed [SAMPLE_W-1:0] sample_level;
      logic signed [SAMPLE_W-1:0] val;
      logic fs;
      harsh = ($urandom_range(0, 9) == 0);
      coef_level = pick_extreme();
      sample_level = pick_extreme();
      if (harsh) begin
         for (int k = 0; k < N_TAPS; k++) begin
            send_word(CMD_COEF, IDX_W'(k), coef_level, 1'($urandom_range(0, 1)));
         end
      end else if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            send_word(CMD_COEF, IDX_W'($urandom), SAMPLE_W'($urandom),
                      1'($urandom_range(0, 1)));
         end
      end
      length = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(8, 40);
      for (int k = 0; k < length; k++) begin
         if ($urandom_range(0, 19) == 0) begin
            send_word(CMD_COEF, IDX_W'($urandom), SAMPLE_W'($urandom),
                      1'($urandom_range(0, 1)));
         end
         if (harsh) val = sample_level;
         else if ($urandom_range(0, 9) == 0) val = pick_extreme();
         else val = SAMPLE_W'($urandom);
         // Now and then a stray frame start breaks the series in the middle.
         fs = (k == 0) || ($urandom_range(0, 49) == 0);
         send_word(CMD_SAMPLE, IDX_W'($urandom), val, fs);
      end
      if ($urandom_range(0, 29) == 0) wait_for_sums();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_sums.size() == 0) begin
               $error("filtered: expected nothing, got %0d", rsp_filtered);
               mismatches++;
            end else begin
               wanted_sum = expected_sums.pop_front();
               sums_checked++;
               if (rsp_filtered !== wanted_sum) begin
                  $error("filtered: expected %0d, got %0d", wanted_sum, rsp_filtered);
                  mismatches++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   initial begin
      row_type row;
      int phase_end;
      for (int j = 0; j < N_TAPS; j++) begin
         coef_copy[j] = '0;
         history[j] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Every tap gets written first so that no unwritten coefficient is ever read.
      for (int k = 0; k < N_TAPS; k++) send_word(CMD_COEF, IDX_W'(k), '0, 1'b0);

      for (int r = 0; r < N_DIRECTED; r++) begin
         row = directed_rows[r];
         if (row.kind == ROW_CSR) begin
            write_csr(row.csr_idx, row.csr_val);
         end else begin
            send_word(row.command, row.coef_index, row.value, row.frame_start);
            if (row.pinned && last_word_summed) begin
               void'(expected_sums.pop_back());
               expected_sums.push_back(row.pinned_sum);
            end
         end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         write_csr(CSR_TAP_COUNT, phase_taps[p]);
         write_csr(CSR_DECIMATE, CSR_DATA_W'(phase_decim[p]));
         if (p < 3) begin
            req_idle_pct = 33;
            rsp_idle_pct = 57;
         end else if (p < 6) begin
            req_idle_pct = 57;
            rsp_idle_pct = 33;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) send_frame();
      end

      wait_for_sums();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d words (%0d samples, %0d tap loads) over %0d register writes.",
               words_sent, samples_sent, coef_loads, csr_writes);
      $display("Checked %0d filter sums with %0d mismatches in %0d cycles.",
               sums_checked, mismatches, cycle_count);
      if (mismatches == 0) begin
         $display("tb_fir_filter_decimating: done, clean");
      end else begin
         $display("tb_fir_filter_decimating: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
sv/fir_dec_pkg.sv
sv/fir_filter_decimating.sv
tb/tb_fir_filter_decimating.sv
